// ===== hdl/limit_order_book_matcher_macros.svh =====
// Assertion macros for the limit order book matcher.
`ifndef LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define LOBM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequence holds in the cycle after the antecedent, outside reset.
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lobm_pkg.sv =====
// Shared types for the limit order book matcher.
package lobm_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_FINISH
    } lobm_state_t;

    typedef struct packed {
        logic pop;
        logic dec;
        logic ins;
    } book_cmd_t;

endpackage

// ===== hdl/lobm_order_if.sv =====
// Order and fill channel interfaces for the limit order book matcher.
interface lobm_order_if #(
    parameter int PRICE_BITS = 11,
    parameter int QTY_BITS   = 16
);
    logic                  valid;
    logic                  ready;
    logic                  buy_or_sell;
    logic [PRICE_BITS-1:0] limit_price;
    logic [QTY_BITS-1:0]   order_quantity;

    modport source (output valid, buy_or_sell, limit_price, order_quantity, input ready);
    modport sink (input valid, buy_or_sell, limit_price, order_quantity, output ready);
endinterface

interface lobm_fill_if #(
    parameter int PRICE_BITS = 11,
    parameter int QTY_BITS   = 16
);
    logic                  valid;
    logic                  ready;
    logic [QTY_BITS-1:0]   fill_quantity;
    logic [PRICE_BITS-1:0] fill_price;
    logic                  residual_dropped;
    logic                  last_fill;

    modport source (output valid, fill_quantity, fill_price, residual_dropped, last_fill,
                    input ready);
    modport sink (input valid, fill_quantity, fill_price, residual_dropped, last_fill,
                  output ready);
endinterface

// ===== hdl/lobm_book.sv =====
// One sorted side of the book: a row of price/quantity cells with prefix valid bits.
module lobm_book
    import lobm_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int PRICE_BITS = 11,
    parameter int QTY_BITS   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  bid_side,
    input  book_cmd_t             cmd,
    input  logic [QTY_BITS-1:0]   dec_qty,
    input  logic [PRICE_BITS-1:0] ins_price,
    input  logic [QTY_BITS-1:0]   ins_qty,
    output logic [PRICE_BITS-1:0] front_price,
    output logic [QTY_BITS-1:0]   front_qty,
    output logic                  empty,
    output logic                  full
);

    logic [PRICE_BITS-1:0] price_reg [DEPTH];
    logic [QTY_BITS-1:0]   qty_reg   [DEPTH];
    logic [DEPTH-1:0]      valid_reg;
    logic [PRICE_BITS-1:0] price_next [DEPTH];
    logic [QTY_BITS-1:0]   qty_next   [DEPTH];
    logic [DEPTH-1:0]      valid_next;
    logic [DEPTH-1:0]      keep;
    logic [DEPTH-1:0]      keep_prev;
    logic [PRICE_BITS-1:0] up_price [DEPTH];
    logic [QTY_BITS-1:0]   up_qty   [DEPTH];
    logic [PRICE_BITS-1:0] dn_price [DEPTH];
    logic [QTY_BITS-1:0]   dn_qty   [DEPTH];

    assign front_price = price_reg[0];
    assign front_qty   = qty_reg[0];
    assign empty       = !valid_reg[0];
    assign full        = valid_reg[DEPTH-1];

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            keep[i] = valid_reg[i] &&
                      (bid_side ? (price_reg[i] >= ins_price) : (price_reg[i] <= ins_price));
        end
        keep_prev = {keep[DEPTH-2:0], 1'b1};
        up_price[0] = ins_price;
        up_qty[0]   = ins_qty;
        for (int i = 1; i < DEPTH; i++)
        begin
            up_price[i] = price_reg[i-1];
            up_qty[i]   = qty_reg[i-1];
        end
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            dn_price[i] = price_reg[i+1];
            dn_qty[i]   = qty_reg[i+1];
        end
        dn_price[DEPTH-1] = price_reg[DEPTH-1];
        dn_qty[DEPTH-1]   = qty_reg[DEPTH-1];
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            price_next[i] = price_reg[i];
            qty_next[i]   = qty_reg[i];
        end
        if (cmd.pop)
        begin
            valid_next = {1'b0, valid_reg[DEPTH-1:1]};
            for (int i = 0; i < DEPTH; i++)
            begin
                price_next[i] = dn_price[i];
                qty_next[i]   = dn_qty[i];
            end
        end
        else if (cmd.dec)
        begin
            qty_next[0] = qty_reg[0] - dec_qty;
        end
        else if (cmd.ins)
        begin
            valid_next = {valid_reg[DEPTH-2:0], 1'b1} | valid_reg;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!keep[i])
                begin
                    if (keep_prev[i])
                    begin
                        price_next[i] = ins_price;
                        qty_next[i]   = ins_qty;
                    end
                    else
                    begin
                        price_next[i] = up_price[i];
                        qty_next[i]   = up_qty[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            price_reg[i] <= price_next[i];
            qty_reg[i]   <= qty_next[i];
        end
    end

endmodule

// ===== hdl/limit_order_book_matcher.sv =====
// Top level of the price-time priority limit order book matcher.
// Usage:
//   order (sink): one limit order per transfer: buy_or_sell, limit_price,
//     order_quantity. ready is high only while the matcher is idle.
//   fill (source): one or more results per order; last_fill marks the final
//     one, which also carries residual_dropped.
// Timing: an order enters in the idle state; the match state takes fills
//   against the opposite book and ends the sweep when the test for a cross
//   fails; the finish state rests the remainder and posts the final result.
//   The single min/subtract unit handles one resting order a cycle unless the
//   output stalls. Each fill is held back until its last_fill flag is known.
// Reset: both books empty, no result pending, order ready.
// Stall: a fill that is not taken holds in the output register and the sweep
//   waits on it; nothing is lost or repeated.
`include "limit_order_book_matcher_macros.svh"

module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int BOOK_DEPTH = 32,
    parameter int PRICE_BITS = 11,
    parameter int QTY_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    lobm_order_if.sink   order,
    lobm_fill_if.source  fill
);

    lobm_state_t           state_reg, state_next;
    logic                  side_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [QTY_BITS-1:0]   qty_reg, qty_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [QTY_BITS-1:0]   pend_qty_reg, pend_qty_next;
    logic [PRICE_BITS-1:0] pend_price_reg, pend_price_next;
    logic                  out_valid_reg, out_valid_next;
    logic [QTY_BITS-1:0]   out_qty_reg, out_qty_next;
    logic [PRICE_BITS-1:0] out_price_reg, out_price_next;
    logic                  out_drop_reg, out_drop_next;
    logic                  out_last_reg, out_last_next;

    book_cmd_t             bid_cmd, ask_cmd, opp_cmd, own_cmd;
    logic [PRICE_BITS-1:0] bid_front_price, ask_front_price, opp_price;
    logic [QTY_BITS-1:0]   bid_front_qty, ask_front_qty, opp_qty;
    logic                  bid_empty, ask_empty, bid_full, ask_full;
    logic                  opp_empty, own_full;
    logic                  crossing, out_free;
    logic [QTY_BITS-1:0]   match_qty, front_left;

    lobm_book #(.DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_bid (
        .clk         (clk),
        .rst_n       (rst_n),
        .bid_side    (1'b1),
        .cmd         (bid_cmd),
        .dec_qty     (match_qty),
        .ins_price   (price_reg),
        .ins_qty     (qty_reg),
        .front_price (bid_front_price),
        .front_qty   (bid_front_qty),
        .empty       (bid_empty),
        .full        (bid_full)
    );

    lobm_book #(.DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_ask (
        .clk         (clk),
        .rst_n       (rst_n),
        .bid_side    (1'b0),
        .cmd         (ask_cmd),
        .dec_qty     (match_qty),
        .ins_price   (price_reg),
        .ins_qty     (qty_reg),
        .front_price (ask_front_price),
        .front_qty   (ask_front_qty),
        .empty       (ask_empty),
        .full        (ask_full)
    );

    assign opp_price = side_reg ? bid_front_price : ask_front_price;
    assign opp_qty   = side_reg ? bid_front_qty : ask_front_qty;
    assign opp_empty = side_reg ? bid_empty : ask_empty;
    assign own_full  = side_reg ? ask_full : bid_full;
    assign crossing  = (qty_reg != '0) && !opp_empty &&
                       (side_reg ? (opp_price >= price_reg) : (price_reg >= opp_price));
    assign match_qty  = (opp_qty < qty_reg) ? opp_qty : qty_reg;
    assign front_left = opp_qty - match_qty;
    assign out_free   = !out_valid_reg || fill.ready;

    assign bid_cmd = side_reg ? opp_cmd : own_cmd;
    assign ask_cmd = side_reg ? own_cmd : opp_cmd;

    assign order.ready           = (state_reg == ST_IDLE);
    assign fill.valid            = out_valid_reg;
    assign fill.fill_quantity    = out_qty_reg;
    assign fill.fill_price       = out_price_reg;
    assign fill.residual_dropped = out_drop_reg;
    assign fill.last_fill        = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (order.valid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (!crossing)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        opp_cmd         = '0;
        own_cmd         = '0;
        qty_next        = qty_reg;
        pend_valid_next = pend_valid_reg;
        pend_qty_next   = pend_qty_reg;
        pend_price_next = pend_price_reg;
        out_valid_next  = out_valid_reg && !fill.ready;
        out_qty_next    = out_qty_reg;
        out_price_next  = out_price_reg;
        out_drop_next   = out_drop_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                qty_next = order.order_quantity;
            end
            ST_MATCH:
            begin
                if (crossing && (!pend_valid_reg || out_free))
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_qty_next   = pend_qty_reg;
                        out_price_next = pend_price_reg;
                        out_drop_next  = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_qty_next   = match_qty;
                    pend_price_next = side_reg ? price_reg : opp_price;
                    qty_next        = qty_reg - match_qty;
                    opp_cmd.pop     = (front_left == '0);
                    opp_cmd.dec     = (front_left != '0);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    own_cmd.ins     = (qty_reg != '0) && !own_full;
                    out_valid_next  = 1'b1;
                    out_qty_next    = pend_valid_reg ? pend_qty_reg : '0;
                    out_price_next  = pend_valid_reg ? pend_price_reg : '0;
                    out_drop_next   = (qty_reg != '0) && own_full;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            side_reg  <= order.buy_or_sell;
            price_reg <= order.limit_price;
        end
        qty_reg        <= qty_next;
        pend_qty_reg   <= pend_qty_next;
        pend_price_reg <= pend_price_next;
        out_qty_reg    <= out_qty_next;
        out_price_reg  <= out_price_next;
        out_drop_reg   <= out_drop_next;
        out_last_reg   <= out_last_next;
    end

    `LOBM_ASSERT_IMP(a_idle_no_pend, state_reg == ST_IDLE, !pend_valid_reg, "fill pending while idle")
    `LOBM_ASSERT_IMP(a_inner_fill_nonzero, out_valid_reg && !out_last_reg, out_qty_reg != '0, "empty inner fill")
    `LOBM_ASSERT_IMP(a_drop_only_last, out_valid_reg && out_drop_reg, out_last_reg, "drop flag on inner fill")
    `LOBM_ASSERT_NEXT(a_finish_done, state_reg == ST_FINISH && out_free, out_valid_reg && out_last_reg, "final result missing")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the limit order book matcher: directed table, then random orders.
`timescale 1ns / 100ps

module tb_top;
    import lobm_pkg::*;

    localparam int BOOK_DEPTH = 32;
    localparam int PRICE_BITS = 11;
    localparam int QTY_BITS   = 16;
    localparam int N_RANDOM   = 110;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic [QTY_BITS-1:0]   qty;
        logic [PRICE_BITS-1:0] price;
        logic                  dropped;
        logic                  last;
    } fill_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } resting_t;

    typedef struct {
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
        bit                    typed;
        fill_t                 fixed;
    } order_row_t;

    logic clk;
    logic rst_n;

    lobm_order_if #(.PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) order ();
    lobm_fill_if  #(.PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) fill ();

    limit_order_book_matcher #(
        .BOOK_DEPTH(BOOK_DEPTH),
        .PRICE_BITS(PRICE_BITS),
        .QTY_BITS(QTY_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .order(order),
        .fill(fill)
    );

    resting_t bid_book[$];
    resting_t ask_book[$];
    fill_t    new_fills[$];
    fill_t    pending_fills[$];

    order_row_t order_table[16];

    int  mismatch_count;
    int  fills_checked;
    int  orders_sent;
    int  drops_seen;
    int  widest_sweep;
    int  cycle_count;
    bit  hold_done;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic match_order(input logic side, input logic [PRICE_BITS-1:0] price,
                               input logic [QTY_BITS-1:0] qty_in);
        logic [QTY_BITS-1:0]   qty;
        logic [QTY_BITS-1:0]   m;
        logic [PRICE_BITS-1:0] rest_price;
        resting_t              entry;
        fill_t                 f;
        int                    pos;
        bit                    dropped;
        new_fills.delete();
        qty = qty_in;
        dropped = 0;
        while (qty != 0)
        begin
            if (side == SIDE_SELL)
            begin
                if (bid_book.size() == 0 || bid_book[0].price < price)
                    break;
                m = (bid_book[0].qty < qty) ? bid_book[0].qty : qty;
                f = '{qty: m, price: price, dropped: 1'b0, last: 1'b0};
                bid_book[0].qty = bid_book[0].qty - m;
                if (bid_book[0].qty == 0)
                    void'(bid_book.pop_front());
            end
            else
            begin
                if (ask_book.size() == 0 || price < ask_book[0].price)
                    break;
                rest_price = ask_book[0].price;
                m = (ask_book[0].qty < qty) ? ask_book[0].qty : qty;
                f = '{qty: m, price: rest_price, dropped: 1'b0, last: 1'b0};
                ask_book[0].qty = ask_book[0].qty - m;
                if (ask_book[0].qty == 0)
                    void'(ask_book.pop_front());
            end
            new_fills.insert(new_fills.size(), f);
            qty = qty - m;
        end
        if (qty != 0)
        begin
            entry = '{price: price, qty: qty};
            pos = 0;
            if (side == SIDE_SELL)
            begin
                if (ask_book.size() >= BOOK_DEPTH)
                    dropped = 1;
                else
                begin
                    while (pos < ask_book.size() && ask_book[pos].price <= price)
                        pos++;
                    ask_book.insert(pos, entry);
                end
            end
            else
            begin
                if (bid_book.size() >= BOOK_DEPTH)
                    dropped = 1;
                else
                begin
                    while (pos < bid_book.size() && bid_book[pos].price >= price)
                        pos++;
                    bid_book.insert(pos, entry);
                end
            end
        end
        if (new_fills.size() == 0)
            new_fills.insert(0, '{qty: '0, price: '0, dropped: 1'b0, last: 1'b0});
        new_fills[new_fills.size()-1].dropped = dropped;
        new_fills[new_fills.size()-1].last = 1'b1;
        if (dropped)
            drops_seen++;
        if (new_fills.size() > widest_sweep)
            widest_sweep = new_fills.size();
    endtask

    int burst_left;

    task automatic place_order(input order_row_t row);
        int gap;
        order.valid          <= 1'b1;
        order.buy_or_sell    <= row.side;
        order.limit_price    <= row.price;
        order.order_quantity <= row.qty;
        do
            @(posedge clk);
        while (!order.ready);
        match_order(row.side, row.price, row.qty);
        if (row.typed)
            pending_fills.insert(pending_fills.size(), row.fixed);
        else
            foreach (new_fills[i])
                pending_fills.insert(pending_fills.size(), new_fills[i]);
        orders_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(0, 7);
            gap = $urandom_range(1, 6);
            order.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic order_row_t random_order(input int idx);
        order_row_t r;
        r.typed = 1'b0;
        r.fixed = '0;
        r.side  = 1'($urandom_range(0, 1));
        r.price = PRICE_BITS'($urandom_range(950, 1050));
        r.qty   = QTY_BITS'($urandom_range(1, 500));
        if (idx < 40)
        begin
            r.side  = SIDE_BUY;
            r.price = PRICE_BITS'($urandom_range(0, 900));
            r.qty   = QTY_BITS'($urandom_range(1, 200));
        end
        else if (idx < 44)
        begin
            r.side  = SIDE_SELL;
            r.price = '0;
            r.qty   = 16'hFFFF;
        end
        else if (idx >= 75 && idx < 100)
        begin
            r.side  = SIDE_SELL;
            r.price = PRICE_BITS'($urandom_range(1500, 2047));
            r.qty   = QTY_BITS'($urandom_range(1, 300));
        end
        else if (idx >= 100 && idx < 104)
        begin
            r.side  = SIDE_BUY;
            r.price = 11'd2047;
            r.qty   = 16'hFFFF;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: r.qty = QTY_BITS'($urandom);
                1: r.qty = '0;
                2: r.price = PRICE_BITS'($urandom);
                default: ;
            endcase
        end
        return r;
    endfunction

    initial
    begin
        fill.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && fills_checked >= 40)
            begin
                hold_done = 1;
                fill.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            case ((cycle_count / 64) % 3)
                0: fill.ready <= 1'b1;
                1: fill.ready <= ($urandom_range(0, 9) < 7);
                default: fill.ready <= (cycle_count % 4 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        fill_t got;
        fill_t want;
        if (rst_n && fill.valid && fill.ready)
        begin
            got = '{qty: fill.fill_quantity, price: fill.fill_price,
                    dropped: fill.residual_dropped, last: fill.last_fill};
            if (pending_fills.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected fill: qty %0d price %0d drop %b last %b",
                             got.qty, got.price, got.dropped, got.last);
            end
            else
            begin
                want = pending_fills.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"fill mismatch: exp qty %0d price %0d drop %b last %b,",
                                  " got qty %0d price %0d drop %b last %b"},
                                 want.qty, want.price, want.dropped, want.last,
                                 got.qty, got.price, got.dropped, got.last);
                end
            end
            fills_checked++;
        end
    end

    initial
    begin
        order.valid          <= 1'b0;
        order.buy_or_sell    <= 1'b0;
        order.limit_price    <= '0;
        order.order_quantity <= '0;
        orders_sent = 0;
        drops_seen = 0;
        widest_sweep = 0;
        burst_left = 0;

        order_table[0]  = '{SIDE_BUY,  11'd0,    16'd1,    1'b1, '{16'd0, 11'd0, 1'b0, 1'b1}};
        order_table[1]  = '{SIDE_SELL, 11'd2047, 16'hFFFF, 1'b1, '{16'd0, 11'd0, 1'b0, 1'b1}};
        order_table[2]  = '{SIDE_BUY,  11'd2047, 16'hFFFF, 1'b1,
                            '{16'hFFFF, 11'd2047, 1'b0, 1'b1}};
        order_table[3]  = '{SIDE_BUY,  11'd100,  16'd0,    1'b1, '{16'd0, 11'd0, 1'b0, 1'b1}};
        order_table[4]  = '{SIDE_SELL, 11'd0,    16'd1,    1'b1, '{16'd1, 11'd0, 1'b0, 1'b1}};
        order_table[5]  = '{SIDE_SELL, 11'd100,  16'd0,    1'b1, '{16'd0, 11'd0, 1'b0, 1'b1}};
        order_table[6]  = '{SIDE_BUY,  11'd100,  16'd10,   1'b0, '0};
        order_table[7]  = '{SIDE_BUY,  11'd100,  16'd20,   1'b0, '0};
        order_table[8]  = '{SIDE_BUY,  11'd105,  16'd5,    1'b0, '0};
        order_table[9]  = '{SIDE_SELL, 11'd100,  16'd40,   1'b0, '0};
        order_table[10] = '{SIDE_BUY,  11'd1500, 16'd3,    1'b0, '0};
        order_table[11] = '{SIDE_SELL, 11'd90,   16'd7,    1'b0, '0};
        order_table[12] = '{SIDE_BUY,  11'd90,   16'd7,    1'b0, '0};
        order_table[13] = '{SIDE_SELL, 11'd1365, 16'h5555, 1'b0, '0};
        order_table[14] = '{SIDE_BUY,  11'd682,  16'hAAAA, 1'b0, '0};
        order_table[15] = '{SIDE_BUY,  11'd1365, 16'h5555, 1'b0, '0};

        @(posedge rst_n);
        @(posedge clk);
        foreach (order_table[i])
            place_order(order_table[i]);
        for (int i = 0; i < N_RANDOM; i++)
            place_order(random_order(i));
        order.valid <= 1'b0;

        while (pending_fills.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d orders, %0d fills checked, widest sweep %0d fills",
                 orders_sent, fills_checked, widest_sweep);
        $display("dropped remainders %0d, mismatches %0d", drops_seen, mismatch_count);
        if (mismatch_count == 0 && pending_fills.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
